// ===== design/lpg_pkg.sv =====
// Shared constants and types for the line pixel generator.
`default_nettype none

package lpg_pkg;

  localparam int GRID_SIZE = 64;
  localparam int COORD_W   = $clog2(GRID_SIZE);
  localparam int STRIDE_W  = 7;
  localparam int ADDR_W    = 32;
  localparam int COLOR_W   = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_STRIDE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE = 1'b1;

  localparam logic [STRIDE_W-1:0] ROW_STRIDE_RESET = STRIDE_W'(64);
  localparam logic [ADDR_W-1:0]   FRAME_BASE_RESET = '0;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SETUP = 3'b010,
    ST_RUN   = 3'b100
  } lpg_state_t;

endpackage

`default_nettype wire

// ===== design/line_pixel_generator.sv =====
// Line rasterizer: one line command in, one pixel item per cycle out unless stalled.
//
// Input channel (in_valid / in_stall): one line command, two endpoints on
// the grid plus a color. in_stall is high while a line is being walked, so
// only one command is in flight at a time.
// Output channel (out_valid / out_stall): one item per pixel with x, y,
// word address frame_base + x + y*row_stride (mod 2^32), color, and
// last_pixel set on the final pixel. Both endpoints are drawn; a single
// point gives one pixel.
// Config channel (cfg_valid / cfg_ready): index 0 row_stride, index 1
// frame_base. cfg_ready is always high. Write only while idle.
// Timing: a setup state after accept, then one pixel per cycle into the
// output register while the output is not stalled. The next command is
// taken once the last pixel has been emitted and the sequencer is idle.
// The pace is set by the remainder step that moves the minor axis per pixel.
// Reset (rst, sync): sequencer goes idle, output empties, registers return
// to stride 64 and base 0. While out_stall is high and an item is held,
// the output register keeps that item and the walk pauses.
`default_nettype none

module line_pixel_generator (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // config write port
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [lpg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lpg_pkg::CFG_DATA_W-1:0] cfg_data,
  // line command
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [lpg_pkg::COORD_W-1:0]   start_x,
  input  wire logic [lpg_pkg::COORD_W-1:0]   start_y,
  input  wire logic [lpg_pkg::COORD_W-1:0]   end_x,
  input  wire logic [lpg_pkg::COORD_W-1:0]   end_y,
  input  wire logic [lpg_pkg::COLOR_W-1:0]   line_color,
  // pixel items
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [lpg_pkg::COORD_W-1:0]        pixel_x,
  output logic [lpg_pkg::COORD_W-1:0]        pixel_y,
  output logic [lpg_pkg::ADDR_W-1:0]         pixel_address,
  output logic [lpg_pkg::COLOR_W-1:0]        pixel_color,
  output logic                               last_pixel
);
  import lpg_pkg::*;

  localparam int PROD_W = COORD_W + STRIDE_W;

  // config registers
  logic [STRIDE_W-1:0] row_stride;
  logic [ADDR_W-1:0]   frame_base;

  // latched command
  logic [COORD_W-1:0] sx, sy, ex, ey;
  logic [COLOR_W-1:0] color;

  // walk state
  lpg_state_t          state;
  logic                x_major;
  logic [COORD_W-1:0]  major;      // current major-axis coordinate
  logic [COORD_W-1:0]  minor;      // current minor-axis coordinate
  logic [COORD_W-1:0]  n;          // major-axis length
  logic [COORD_W-1:0]  k;          // pixel index along the line
  logic [COORD_W-1:0]  rem;        // remainder of d*k/n, 0..n-1
  logic signed [COORD_W:0] d;      // signed minor-axis delta

  // setup logic
  logic [COORD_W-1:0] adx, ady;
  logic               setup_xmaj;
  logic               setup_swap;

  always_comb begin
    adx = (ex > sx) ? ex - sx : sx - ex;
    ady = (ey > sy) ? ey - sy : sy - ey;
    setup_xmaj = (sx != ex) && (ady <= adx);
    setup_swap = setup_xmaj ? (sx > ex) : (sy > ey);
  end

  // pixel and address for the current step
  logic [COORD_W-1:0] cur_x, cur_y;
  logic [PROD_W-1:0]  y_times_stride;
  logic [ADDR_W-1:0]  cur_addr;
  logic               emit;
  logic               is_last;

  always_comb begin
    cur_x = x_major ? major : minor;
    cur_y = x_major ? minor : major;
    y_times_stride = PROD_W'(cur_y) * PROD_W'(row_stride);
    cur_addr = frame_base + ADDR_W'(cur_x) + ADDR_W'(y_times_stride);
    emit = (state == ST_RUN) && (!out_valid || !out_stall);
    is_last = (k == n);
  end

  // shared remainder step: floor walk of d*k/n
  logic signed [COORD_W+1:0] rem_sum;
  logic signed [COORD_W+1:0] n_s;
  logic [COORD_W-1:0]        rem_next;
  logic [COORD_W-1:0]        minor_next;

  always_comb begin
    n_s = $signed({2'b00, n});
    rem_sum = $signed({2'b00, rem}) + $signed({d[COORD_W], d});
    rem_next = rem_sum[COORD_W-1:0];
    minor_next = minor;
    if (!d[COORD_W] && (rem_sum >= n_s)) begin
      rem_next = COORD_W'(rem_sum - n_s);
      minor_next = minor + COORD_W'(1);
    end else if (d[COORD_W] && (rem_sum < 0)) begin
      rem_next = COORD_W'(rem_sum + n_s);
      minor_next = minor - COORD_W'(1);
    end
  end

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_stride <= ROW_STRIDE_RESET;
      frame_base <= FRAME_BASE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROW_STRIDE: row_stride <= cfg_data[STRIDE_W-1:0];
        REG_FRAME_BASE: frame_base <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) state <= ST_SETUP;
        end
        ST_SETUP: state <= ST_RUN;
        ST_RUN: begin
          if (emit && is_last) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      sx    <= start_x;
      sy    <= start_y;
      ex    <= end_x;
      ey    <= end_y;
      color <= line_color;
    end
    if (state == ST_SETUP) begin
      x_major <= setup_xmaj;
      k       <= '0;
      rem     <= '0;
      if (setup_xmaj) begin
        n     <= adx;
        major <= setup_swap ? ex : sx;
        minor <= setup_swap ? ey : sy;
        d     <= setup_swap ? $signed({1'b0, sy}) - $signed({1'b0, ey})
                            : $signed({1'b0, ey}) - $signed({1'b0, sy});
      end else begin
        n     <= ady;
        major <= setup_swap ? ey : sy;
        minor <= setup_swap ? ex : sx;
        d     <= setup_swap ? $signed({1'b0, sx}) - $signed({1'b0, ex})
                            : $signed({1'b0, ex}) - $signed({1'b0, sx});
      end
    end else if (emit) begin
      k     <= k + COORD_W'(1);
      major <= major + COORD_W'(1);
      minor <= minor_next;
      rem   <= rem_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pixel_x       <= cur_x;
      pixel_y       <= cur_y;
      pixel_address <= cur_addr;
      pixel_color   <= color;
      last_pixel    <= is_last;
    end
  end

`ifndef ASSERT_OFF
  a_accept_to_setup: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == ST_SETUP))
    else $error("accepted command did not start setup");

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (k <= n))
    else $error("pixel index ran past line length");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> ((rem < n) || (rem == '0)))
    else $error("remainder out of range");

  a_last_ends_walk: assert property (@(posedge clk) disable iff (rst)
    (emit && is_last) |=> (state == ST_IDLE) && out_valid && last_pixel)
    else $error("last pixel did not end the walk");
`endif

endmodule

`default_nettype wire

// ===== sim/line_pixel_generator_test.sv =====
// Self-checking testbench for line_pixel_generator: random lines and registers, scoreboarded pixels.
`timescale 1ns / 100ps

module line_pixel_generator_test;
  import lpg_pkg::*;

  localparam int CLK_HALF        = 10;         // 20 ns period
  localparam int RESET_CYCLES    = 6;
  localparam int CYCLE_LIMIT     = 1_000_000;  // watchdog, far beyond the slowest legal run
  localparam int DRAIN_PAD       = 8;          // margin after the last owed pixel has been taken
  localparam int HOLD_CYCLES     = 400;        // long output hold-off
  localparam int RANDOM_PHASES   = 6;
  localparam int LINES_PER_PHASE = 70;
  localparam int MAX_COORD       = GRID_SIZE - 1;

  // One line command as driven on the input channel.
  typedef struct packed {
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    logic [COORD_W-1:0] ex;
    logic [COORD_W-1:0] ey;
    logic [COLOR_W-1:0] color;
  } line_cmd_t;

  // One pixel item, laid out in output port order.
  typedef struct packed {
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] color;
    logic               is_last;
  } pixel_t;

  // Receiver behavior: free running, sparse stalls, dense stalls, alternating stalls.
  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

  // Clock, reset and every block input start at known values.
  logic                  clk        = 1'b0;
  logic                  rst        = 1'b1;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = REG_ROW_STRIDE;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  in_valid   = 1'b0;
  logic                  in_stall;
  logic [COORD_W-1:0]    start_x    = '0;
  logic [COORD_W-1:0]    start_y    = '0;
  logic [COORD_W-1:0]    end_x      = '0;
  logic [COORD_W-1:0]    end_y      = '0;
  logic [COLOR_W-1:0]    line_color = '0;
  logic                  out_valid;
  logic                  out_stall  = 1'b0;
  logic [COORD_W-1:0]    pixel_x;
  logic [COORD_W-1:0]    pixel_y;
  logic [ADDR_W-1:0]     pixel_address;
  logic [COLOR_W-1:0]    pixel_color;
  logic                  last_pixel;

  // Predictor copy of the two registers.
  logic [STRIDE_W-1:0] stride_now = ROW_STRIDE_RESET;
  logic [ADDR_W-1:0]   base_now   = FRAME_BASE_RESET;

  pixel_t   pixel_q[$];           // pixels still owed by the block, oldest first
  int       error_count   = 0;
  int       burst_left    = 0;    // items left in the current sender burst
  bit       sender_gaps_on = 1'b1;
  bit       hold_request  = 1'b0; // set by a test, taken by the receiver process
  int       hold_left     = 0;
  int       mode_left     = 0;
  rx_mode_t rx_mode       = RX_FREE;

  line_pixel_generator i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .start_x       (start_x),
    .start_y       (start_y),
    .end_x         (end_x),
    .end_y         (end_y),
    .line_color    (line_color),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .pixel_address (pixel_address),
    .pixel_color   (pixel_color),
    .last_pixel    (last_pixel)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Line predictor
  // ---------------------------------------------------------------------

  // floor(num*k/den) for den > 0, num of either sign.
  function automatic int floor_step(input int num, input int k, input int den);
    if (num >= 0)
      return (num * k) / den;
    return -(((-num) * k + den - 1) / den);
  endfunction

  // Queue every pixel of one accepted line. Coordinates are 6 bits, so they
  // never exceed GRID_SIZE-1 and need no saturation.
  function automatic void predict_line(input line_cmd_t c);
    int x0, y0, x1, y1, adx, ady, n, k, t, x, y;
    bit x_major;
    pixel_t p;
    x0 = int'(c.sx);
    y0 = int'(c.sy);
    x1 = int'(c.ex);
    y1 = int'(c.ey);
    adx = (x1 > x0) ? x1 - x0 : x0 - x1;
    ady = (y1 > y0) ? y1 - y0 : y0 - y1;
    // Shallow lines walk x, steep lines and points walk y; always ascending.
    x_major = (x0 != x1) && (ady <= adx);
    if (x_major ? (x0 > x1) : (y0 > y1)) begin
      t = x0; x0 = x1; x1 = t;
      t = y0; y0 = y1; y1 = t;
    end
    n = x_major ? x1 - x0 : y1 - y0;
    for (k = 0; k <= n; k++) begin
      if (x_major) begin
        x = x0 + k;
        y = y0 + floor_step(y1 - y0, k, n);
      end else begin
        // a single point has n == 0 and only the k == 0 pixel
        x = x0 + ((n == 0) ? 0 : floor_step(x1 - x0, k, n));
        y = y0 + k;
      end
      p.px      = COORD_W'(x);
      p.py      = COORD_W'(y);
      p.addr    = base_now + ADDR_W'(x) + ADDR_W'(y) * ADDR_W'(stride_now);
      p.color   = c.color;
      p.is_last = (k == n);
      pixel_q.push_back(p);
    end
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Drive one line command at the falling edge and hold it until taken.
  // Valid stays high afterward so back-to-back items see no bubble.
  task automatic send_line(input line_cmd_t c);
    int gap;
    @(negedge clk);
    if (sender_gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 12);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 10);
    end
    {start_x, start_y, end_x, end_y, line_color} = c;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_line(c);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic send_segment(input int sx, input int sy, input int ex, input int ey,
                              input logic [COLOR_W-1:0] color);
    send_line({COORD_W'(sx), COORD_W'(sy), COORD_W'(ex), COORD_W'(ey), color});
  endtask

  // Sender pause: drop valid and wait out every owed pixel plus the tail.
  task automatic wait_for_pixels();
    @(negedge clk);
    in_valid = 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  // Register write; only called while the block is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_ROW_STRIDE)
      stride_now = data[STRIDE_W-1:0];
    else if (idx == REG_FRAME_BASE)
      base_now = data;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Write both registers in random order; stride data carries junk above bit 6.
  task automatic set_registers(input logic [STRIDE_W-1:0] stride, input logic [ADDR_W-1:0] base);
    logic [CFG_DATA_W-1:0] stride_data;
    stride_data = $urandom;
    stride_data[STRIDE_W-1:0] = stride;
    if ($urandom_range(0, 1)) begin
      write_reg(REG_ROW_STRIDE, stride_data);
      write_reg(REG_FRAME_BASE, base);
    end else begin
      write_reg(REG_FRAME_BASE, base);
      write_reg(REG_ROW_STRIDE, stride_data);
    end
  endtask

  // Coordinates biased toward the grid edges.
  function automatic int pick_coord();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return MAX_COORD;
      default: return $urandom_range(0, MAX_COORD);
    endcase
  endfunction

  // Mix of points, axis lines, short stubs and arbitrary lines.
  function automatic line_cmd_t random_line();
    int sx, sy, ex, ey, kind;
    sx = pick_coord();
    sy = pick_coord();
    ex = pick_coord();
    ey = pick_coord();
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      ex = sx;
      ey = sy;
    end else if (kind <= 2) begin
      ey = sy;
    end else if (kind <= 4) begin
      ex = sx;
    end else if (kind <= 7) begin
      ex = sx + $urandom_range(0, 6) - 3;
      ey = sy + $urandom_range(0, 6) - 3;
      ex = (ex < 0) ? 0 : (ex > MAX_COORD) ? MAX_COORD : ex;
      ey = (ey < 0) ? 0 : (ey > MAX_COORD) ? MAX_COORD : ey;
    end
    return {COORD_W'(sx), COORD_W'(sy), COORD_W'(ex), COORD_W'(ey), COLOR_W'($urandom)};
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset registers (stride 64, base 0): points, axis lines, diagonals,
  // reversed endpoints, the |dy| == |dx| tie, one-step lines, color extremes.
  task automatic test_directed_lines();
    send_segment( 0,  0,  0,  0, 32'h0000_0000);  // single point at origin
    send_segment(63, 63, 63, 63, 32'hFFFF_FFFF);  // single point at far corner
    send_segment( 0,  0, 63,  0, 32'hAAAA_AAAA);  // full row
    send_segment(63, 63,  0, 63, 32'h5555_5555);  // full row, right to left
    send_segment( 0,  0,  0, 63, 32'h0F0F_0F0F);  // full column
    send_segment(63, 63, 63,  0, 32'hF0F0_F0F0);  // full column, bottom to top
    send_segment( 0,  0, 63, 63, 32'h1234_5678);  // main diagonal
    send_segment( 0, 63, 63,  0, 32'h8765_4321);  // anti-diagonal
    send_segment(63,  0,  0, 63, $urandom);       // anti-diagonal reversed
    send_segment( 0, 10, 40, 25, $urandom);       // shallow, rising
    send_segment( 5, 50, 60,  3, $urandom);       // shallow, falling: floor of negatives
    send_segment(10,  0, 25, 40, $urandom);       // steep, rising
    send_segment(50,  5,  3, 60, $urandom);       // steep, x falling
    send_segment(20, 60, 30,  1, $urandom);       // steep, reversed
    send_segment(10, 20, 20, 10, $urandom);       // slope tie walks x
    send_segment( 7,  7,  8,  7, $urandom);       // two pixels across
    send_segment( 7,  7,  7,  8, $urandom);       // two pixels down
    send_segment( 8,  8,  7,  7, $urandom);       // two pixels diagonal, reversed
    send_segment( 0,  0,  1, 63, $urandom);       // dx of one over the full height
    send_segment( 0, 63, 63, 62, $urandom);       // dy of one over the full width
    send_segment(62,  1,  1, 62, $urandom);
    wait_for_pixels();
  endtask

  // Stride at 0, 1, 64, 65 and 127, base at zero and near wrap.
  task automatic test_register_extremes();
    logic [STRIDE_W-1:0] strides [6] = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd65, 7'd64};
    logic [ADDR_W-1:0]   bases   [6];
    int i;
    bases = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h1234_5678, 32'hFFFF_FF00, $urandom,
              FRAME_BASE_RESET};
    for (i = 0; i < 6; i++) begin
      set_registers(strides[i], bases[i]);
      send_segment(0, 0, 63, 63, $urandom);       // spans the whole address range
      send_segment(63, 63, 63, 63, $urandom);
      send_line(random_line());
      wait_for_pixels();
    end
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  // back to back; the block must fill and stall its input, then drain.
  task automatic test_output_hold();
    int i;
    sender_gaps_on = 1'b0;
    @(posedge clk);
    hold_request = 1'b1;
    for (i = 0; i < 6; i++)
      send_line(random_line());
    wait_for_pixels();
    sender_gaps_on = 1'b1;
  endtask

  // Random lines over several register settings, drained between phases.
  task automatic test_random_lines();
    logic [STRIDE_W-1:0] stride;
    logic [ADDR_W-1:0]   base;
    int phase, i;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 5))
        0:       stride = 7'd0;
        1:       stride = 7'd1;
        2:       stride = 7'd64;
        3:       stride = 7'd127;
        default: stride = STRIDE_W'($urandom_range(0, 127));
      endcase
      base = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFC0 : $urandom;
      set_registers(stride, base);
      // every third phase runs the sender with no gaps at all
      sender_gaps_on = (phase % 3 != 2);
      for (i = 0; i < LINES_PER_PHASE; i++)
        send_line(random_line());
      wait_for_pixels();
    end
    sender_gaps_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random stall modes in runs; a requested hold overrides them.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (rx_mode)
        RX_FREE:   out_stall = 1'b0;
        RX_LIGHT:  out_stall = ($urandom_range(0, 3) == 0);
        RX_HEAVY:  out_stall = ($urandom_range(0, 3) != 0);
        RX_TOGGLE: out_stall = ~out_stall;
        default:   out_stall = 1'b0;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Pixel checker: every accepted pixel against the oldest owed pixel.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : check_pixels
    pixel_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = {pixel_x, pixel_y, pixel_address, pixel_color, last_pixel};
      if (pixel_q.size() == 0) begin
        error_count++;
        $display("%0t: unexpected pixel exp none got x=%0d y=%0d addr=%h color=%h last=%b",
                 $time, got.px, got.py, got.addr, got.color, got.is_last);
      end else begin
        want = pixel_q.pop_front();
        if (got !== want) begin
          error_count++;
          $display("%0t: pixel mismatch exp x=%0d y=%0d addr=%h color=%h last=%b",
                   $time, want.px, want.py, want.addr, want.color, want.is_last,
                   " got x=%0d y=%0d addr=%h color=%h last=%b",
                   got.px, got.py, got.addr, got.color, got.is_last);
        end
      end
    end
  end

  // Watchdog on cycle count.
  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("line_pixel_generator test failed");
    $finish;
  end

  // Sequence: reset once, then each test in turn, then the verdict.
  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst = 1'b0;
    test_directed_lines();
    test_register_extremes();
    test_output_hold();
    test_random_lines();
    wait_for_pixels();
    if (error_count == 0)
      $display("line_pixel_generator test passed");
    else
      $display("line_pixel_generator test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
design/lpg_pkg.sv
design/line_pixel_generator.sv
sim/line_pixel_generator_test.sv
